### hw/rtl/dwps_pkg.sv
// ----------------------------------------------------------------------------
// dwps_pkg: shared types and constants for the dual wheel PI sync unit
// Holds the fixed field widths, reset values, Q-format shift and the
// action and register codes used by the unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dwps_pkg;

  // Fixed field widths.
  localparam int GAIN_W   = 24;
  localparam int SPEED_W  = 16;
  localparam int COUNT_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Gains are Q0.24; half of the compensation lands in Q1.15.
  localparam int GAIN_FRAC_BITS = 24;
  localparam int COMP_SHIFT     = GAIN_FRAC_BITS - 14;

  // Reset values of the configuration registers.
  localparam logic [GAIN_W-1:0]         PROP_GAIN_RST  = 24'd6711;
  localparam logic [GAIN_W-1:0]         INTEG_GAIN_RST = 24'd671;
  localparam logic signed [SPEED_W-1:0] ORIGIN_RST     = 16'sd3277;

  // Limits of a Q1.15 drive value.
  localparam logic signed [SPEED_W-1:0] SPEED_MAX = 16'sh7FFF;
  localparam logic signed [SPEED_W-1:0] SPEED_MIN = 16'sh8000;

  // Item action codes.
  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_RESTART = 2'd1,
    ACT_LOAD    = 2'd2
  } action_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN    = 2'd0,
    REG_INTEG_GAIN   = 2'd1,
    REG_ORIGIN_RIGHT = 2'd2,
    REG_ORIGIN_LEFT  = 2'd3
  } cfg_reg_t;

endpackage

`default_nettype wire

### hw/rtl/dual_wheel_pi_sync_unit.sv
// ----------------------------------------------------------------------------
// dual_wheel_pi_sync_unit: PI synchronisation of two wheel drives
// Accumulates encoder counts into saturating totals, forms a proportional
// plus integral compensation from the count and total differences, and
// moves the two Q1.15 drive values against each other by half of it.
// ----------------------------------------------------------------------------
//
//   channel   handshake                  payload
//   -------   ------------------------   ---------------------------------
//   item      item_valid / item_ready    action, count_right, count_left,
//                                        speed_right_in, speed_left_in
//   result    result_valid/result_ready  speed_right, speed_left, saturated
//   cfg       cfg_valid / cfg_ready      cfg_index, cfg_data
//
// Each item is worked combinationally between the input handshake and the
// result register, so one item per cycle is sustained while results are taken;
// the result appears in the cycle after acceptance. The path is set by the integral multiplier
// (24 by DIST_MAG_W bits, TOTAL_WIDTH capped at 41) followed by the add, shift and speed clip.
// Reset clears the totals and loads gains, origins and drives with their
// reset values. A result held by a stalled consumer blocks the next item only
// while result_ready is low; cfg_ready is always high.
`default_nettype none

module dual_wheel_pi_sync_unit #(
  parameter int TOTAL_WIDTH = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // Item channel.
  input  wire logic                                 item_valid,
  output logic                                      item_ready,
  input  wire logic [1:0]                           action,
  input  wire logic signed [dwps_pkg::COUNT_W-1:0]  count_right,
  input  wire logic signed [dwps_pkg::COUNT_W-1:0]  count_left,
  input  wire logic signed [dwps_pkg::SPEED_W-1:0]  speed_right_in,
  input  wire logic signed [dwps_pkg::SPEED_W-1:0]  speed_left_in,
  // Result channel.
  output logic                                      result_valid,
  input  wire logic                                 result_ready,
  output logic signed [dwps_pkg::SPEED_W-1:0]       speed_right,
  output logic signed [dwps_pkg::SPEED_W-1:0]       speed_left,
  output logic                                      saturated,
  // Configuration channel.
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [dwps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [dwps_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int TW = TOTAL_WIDTH;
  // Distance magnitudes beyond 2^40 already drive both speeds to a limit.
  localparam int DIST_MAG_W = (TW > 40) ? 41 : TW;
  localparam int COMP_W     = dwps_pkg::GAIN_W + DIST_MAG_W + 2;
  localparam int HALF_W     = COMP_W - dwps_pkg::COMP_SHIFT;
  localparam int DRV_W      = HALF_W + 1;
  localparam int SW         = dwps_pkg::SPEED_W;
  localparam int PROD_P_W   = dwps_pkg::GAIN_W + SW;
  localparam int PROD_I_W   = dwps_pkg::GAIN_W + DIST_MAG_W;
  localparam logic [TW-1:0] DIST_CLAMP = {{(TW-1){1'b0}}, 1'b1} << (DIST_MAG_W - 1);

  // Configuration and state registers.
  logic [dwps_pkg::GAIN_W-1:0] prop_gain;
  logic [dwps_pkg::GAIN_W-1:0] integ_gain;
  logic signed [SW-1:0]        origin_speed_right;
  logic signed [SW-1:0]        origin_speed_left;
  logic signed [TW-1:0]        total_right;
  logic signed [TW-1:0]        total_left;
  logic signed [SW-1:0]        drive_right;
  logic signed [SW-1:0]        drive_left;
  logic signed [TW-1:0]        total_right_next;
  logic signed [TW-1:0]        total_left_next;
  logic signed [SW-1:0]        drive_right_next;
  logic signed [SW-1:0]        drive_left_next;
  logic                        saturated_next;

  // Datapath signals.
  logic                 item_accept;
  logic signed [TW:0]   sum_right;
  logic signed [TW:0]   sum_left;
  logic                 ovf_right;
  logic                 ovf_left;
  logic signed [TW-1:0] tick_total_right;
  logic signed [TW-1:0] tick_total_left;
  logic [TW-1:0]        abs_total_right;
  logic [TW-1:0]        abs_total_left;
  logic signed [TW:0]   dist_diff;
  logic                 dist_neg;
  logic [TW:0]          dist_abs;
  logic [DIST_MAG_W-1:0] dist_mag;
  logic [SW:0]          cnt_ext_right;
  logic [SW:0]          cnt_ext_left;
  logic [SW:0]          abs_cnt_right;
  logic [SW:0]          abs_cnt_left;
  logic [SW+1:0]        spd_diff;
  logic                 spd_neg;
  logic [SW+1:0]        spd_abs;
  logic [SW-1:0]        spd_mag;
  logic [PROD_P_W-1:0]  prod_p;
  logic [PROD_I_W-1:0]  prod_i;
  logic signed [COMP_W-1:0] term_p;
  logic signed [COMP_W-1:0] term_i;
  logic signed [COMP_W-1:0] comp;
  logic signed [HALF_W-1:0] half;
  logic                 fwd_right;
  logic                 fwd_left;
  logic signed [DRV_W-1:0] drv_sum_right;
  logic signed [DRV_W-1:0] drv_sum_left;
  logic [SW:0]          clip_right;
  logic [SW:0]          clip_left;

  // Clips a wide drive value to Q1.15; the top bit reports clipping.
  function automatic logic [SW:0] clip_speed(input logic signed [DRV_W-1:0] v);
    logic all_ones;
    logic all_zero;
    all_ones = &v[DRV_W-1:SW-1];
    all_zero = ~|v[DRV_W-1:SW-1];
    if (all_ones || all_zero) begin
      clip_speed = {1'b0, v[SW-1:0]};
    end else if (v[DRV_W-1]) begin
      clip_speed = {1'b1, dwps_pkg::SPEED_MIN};
    end else begin
      clip_speed = {1'b1, dwps_pkg::SPEED_MAX};
    end
  endfunction

  // Handshakes: the result register frees as its item is taken.
  assign item_ready  = !result_valid || result_ready;
  assign item_accept = item_valid && item_ready;
  assign cfg_ready   = 1'b1;

  // Saturating running totals.
  assign sum_right = (TW+1)'(total_right) + (TW+1)'(count_right);
  assign sum_left  = (TW+1)'(total_left) + (TW+1)'(count_left);
  assign ovf_right = sum_right[TW] ^ sum_right[TW-1];
  assign ovf_left  = sum_left[TW] ^ sum_left[TW-1];
  assign tick_total_right = !ovf_right ? sum_right[TW-1:0] :
                            (sum_right[TW] ? {1'b1, {(TW-1){1'b0}}} : {1'b0, {(TW-1){1'b1}}});
  assign tick_total_left  = !ovf_left ? sum_left[TW-1:0] :
                            (sum_left[TW] ? {1'b1, {(TW-1){1'b0}}} : {1'b0, {(TW-1){1'b1}}});

  // Distance error as sign and clamped magnitude.
  assign abs_total_right = tick_total_right[TW-1] ? (~tick_total_right + 1'b1) : tick_total_right;
  assign abs_total_left  = tick_total_left[TW-1] ? (~tick_total_left + 1'b1) : tick_total_left;
  assign dist_diff = {1'b0, abs_total_right} - {1'b0, abs_total_left};
  assign dist_neg  = dist_diff[TW];
  assign dist_abs  = dist_neg ? (~dist_diff + 1'b1) : dist_diff;
  assign dist_mag  = (dist_abs[TW-1:0] > DIST_CLAMP) ? DIST_CLAMP[DIST_MAG_W-1:0] :
                     dist_abs[DIST_MAG_W-1:0];

  // Speed error as sign and magnitude.
  assign cnt_ext_right = {count_right[SW-1], count_right};
  assign cnt_ext_left  = {count_left[SW-1], count_left};
  assign abs_cnt_right = count_right[SW-1] ? (~cnt_ext_right + 1'b1) : cnt_ext_right;
  assign abs_cnt_left  = count_left[SW-1] ? (~cnt_ext_left + 1'b1) : cnt_ext_left;
  assign spd_diff = {1'b0, abs_cnt_right} - {1'b0, abs_cnt_left};
  assign spd_neg  = spd_diff[SW+1];
  assign spd_abs  = spd_neg ? (~spd_diff + 1'b1) : spd_diff;
  assign spd_mag  = spd_abs[SW-1:0];

  // Compensation in Q.24, then half of it in Q1.15 (floor shift).
  assign prod_p = prop_gain * spd_mag;
  assign prod_i = integ_gain * dist_mag;
  assign term_p = spd_neg ? -COMP_W'(prod_p) : COMP_W'(prod_p);
  assign term_i = dist_neg ? -COMP_W'(prod_i) : COMP_W'(prod_i);
  assign comp   = term_p + term_i;
  assign half   = HALF_W'(comp >>> dwps_pkg::COMP_SHIFT);

  // Right drops and left rises by half, each in its own direction of travel.
  assign fwd_right = !drive_right[SW-1] && (|drive_right);
  assign fwd_left  = !drive_left[SW-1] && (|drive_left);
  assign drv_sum_right = fwd_right ? (DRV_W'(drive_right) - DRV_W'(half)) :
                                     (DRV_W'(drive_right) + DRV_W'(half));
  assign drv_sum_left  = fwd_left ? (DRV_W'(drive_left) + DRV_W'(half)) :
                                    (DRV_W'(drive_left) - DRV_W'(half));
  assign clip_right = clip_speed(drv_sum_right);
  assign clip_left  = clip_speed(drv_sum_left);

  // Next state by action.
  always_comb begin
    total_right_next = total_right;
    total_left_next  = total_left;
    drive_right_next = drive_right;
    drive_left_next  = drive_left;
    saturated_next   = 1'b0;
    case (action)
      dwps_pkg::ACT_TICK: begin
        total_right_next = tick_total_right;
        total_left_next  = tick_total_left;
        drive_right_next = clip_right[SW-1:0];
        drive_left_next  = clip_left[SW-1:0];
        saturated_next   = ovf_right || ovf_left || clip_right[SW] || clip_left[SW];
      end
      dwps_pkg::ACT_RESTART: begin
        total_right_next = '0;
        total_left_next  = '0;
        drive_right_next = origin_speed_right;
        drive_left_next  = origin_speed_left;
      end
      dwps_pkg::ACT_LOAD: begin
        drive_right_next = speed_right_in;
        drive_left_next  = speed_left_in;
      end
      default: begin
        // The spare code leaves the state alone and reports the drives.
      end
    endcase
  end

  // Configuration, state and result control.
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain          <= dwps_pkg::PROP_GAIN_RST;
      integ_gain         <= dwps_pkg::INTEG_GAIN_RST;
      origin_speed_right <= dwps_pkg::ORIGIN_RST;
      origin_speed_left  <= dwps_pkg::ORIGIN_RST;
      total_right        <= '0;
      total_left         <= '0;
      drive_right        <= dwps_pkg::ORIGIN_RST;
      drive_left         <= dwps_pkg::ORIGIN_RST;
      result_valid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          dwps_pkg::REG_PROP_GAIN:    prop_gain          <= cfg_data;
          dwps_pkg::REG_INTEG_GAIN:   integ_gain         <= cfg_data;
          dwps_pkg::REG_ORIGIN_RIGHT: origin_speed_right <= cfg_data[SW-1:0];
          dwps_pkg::REG_ORIGIN_LEFT:  origin_speed_left  <= cfg_data[SW-1:0];
          default: begin
          end
        endcase
      end
      if (item_accept) begin
        total_right  <= total_right_next;
        total_left   <= total_left_next;
        drive_right  <= drive_right_next;
        drive_left   <= drive_left_next;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (item_accept) begin
      speed_right <= drive_right_next;
      speed_left  <= drive_left_next;
      saturated   <= saturated_next;
    end
  end

  // A shown result always matches the drive state it came from.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (speed_right == drive_right) && (speed_left == drive_left))
    else $error("result payload differs from drive state");

  // A restart clears both totals and reports no clipping.
  assert property (@(posedge clk) disable iff (rst)
    (item_accept && (action == dwps_pkg::ACT_RESTART)) |=>
      (total_right == '0) && (total_left == '0) && !saturated && result_valid)
    else $error("restart did not clear the totals");

  // A load moves the item's speeds straight to the result.
  assert property (@(posedge clk) disable iff (rst)
    (item_accept && (action == dwps_pkg::ACT_LOAD)) |=>
      (speed_right == $past(speed_right_in)) && (speed_left == $past(speed_left_in)))
    else $error("load did not set the drives");

endmodule

`default_nettype wire
